// ===== rtl/core/owrm_pkg.sv =====
// owrm_pkg: shared types, constants and helper functions for the 1-wire read rom master
// no dependencies
package owrm_pkg;

    localparam int unsigned TICK_W     = 10;
    localparam int unsigned SLOT_W     = 8;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 10;
    localparam int unsigned ROM_W      = 64;
    localparam int unsigned SERIAL_W   = 48;
    localparam int unsigned STATUS_W   = 2;

    localparam logic [SLOT_W-1:0] RECOVERY_TICKS = 8'd5;
    localparam logic [7:0]        CMD_READ_ROM   = 8'h33;
    localparam logic [7:0]        CRC_POLY       = 8'h8C;

    localparam logic [TICK_W-1:0] RST_RESET_LOW_TICKS      = 10'd540;
    localparam logic [TICK_W-1:0] RST_PRESENCE_SAMPLE_TICK = 10'd68;
    localparam logic [TICK_W-1:0] RST_RESET_HIGH_TICKS     = 10'd305;
    localparam logic [SLOT_W-1:0] RST_SLOT_TICKS           = 8'd65;
    localparam logic [SLOT_W-1:0] RST_WRITE_ZERO_LOW_TICKS = 8'd90;
    localparam logic [SLOT_W-1:0] RST_WRITE_ONE_LOW_TICKS  = 8'd10;
    localparam logic [SLOT_W-1:0] RST_READ_LOW_TICKS       = 8'd6;
    localparam logic [SLOT_W-1:0] RST_READ_SAMPLE_TICK     = 8'd15;

    localparam logic [STATUS_W-1:0] STATUS_CRC_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_CRC_FAIL    = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_NO_PRESENCE = 2'd2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_RESET_LOW_TICKS      = 3'd0,
        REG_PRESENCE_SAMPLE_TICK = 3'd1,
        REG_RESET_HIGH_TICKS     = 3'd2,
        REG_SLOT_TICKS           = 3'd3,
        REG_WRITE_ZERO_LOW_TICKS = 3'd4,
        REG_WRITE_ONE_LOW_TICKS  = 3'd5,
        REG_READ_LOW_TICKS       = 3'd6,
        REG_READ_SAMPLE_TICK     = 3'd7
    } cfg_idx_t;

    typedef enum logic [6:0] {
        PH_IDLE     = 7'b0000001,
        PH_RST_LOW  = 7'b0000010,
        PH_RST_HIGH = 7'b0000100,
        PH_WR_LOW   = 7'b0001000,
        PH_WR_REL   = 7'b0010000,
        PH_RD_LOW   = 7'b0100000,
        PH_RD_REL   = 7'b1000000
    } phase_t;

    typedef struct packed {
        logic [TICK_W-1:0] reset_low_ticks;
        logic [TICK_W-1:0] presence_sample_tick;
        logic [TICK_W-1:0] reset_high_ticks;
        logic [SLOT_W-1:0] slot_ticks;
        logic [SLOT_W-1:0] write_zero_low_ticks;
        logic [SLOT_W-1:0] write_one_low_ticks;
        logic [SLOT_W-1:0] read_low_ticks;
        logic [SLOT_W-1:0] read_sample_tick;
    } cfg_t;

    typedef struct packed {
        logic                drive_low;
        logic                busy_res;
        logic                done_res;
        logic [STATUS_W-1:0] status;
        logic [7:0]          family_code;
        logic [SERIAL_W-1:0] serial_number;
        logic [7:0]          crc_byte;
    } result_t;

    function automatic logic [SLOT_W-1:0] sub_sat(input logic [SLOT_W-1:0] a,
                                                  input logic [SLOT_W-1:0] b);
        sub_sat = (a > b) ? (a - b) : '0;
    endfunction

    // reflected crc-8, one byte
    function automatic logic [7:0] crc8_step(input logic [7:0] acc, input logic [7:0] data);
        logic [7:0] c;
        c = acc ^ data;
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        crc8_step = c;
    endfunction

endpackage

// ===== rtl/core/owrm_tick_if.sv =====
// owrm_tick_if: input channel carrying one tick word (start request and line level)
// depends on owrm_pkg conventions only
interface owrm_tick_if;
    logic valid;
    logic ready;
    logic start_req;
    logic line_level;

    modport source (output valid, output start_req, output line_level, input ready);
    modport sink   (input valid, input start_req, input line_level, output ready);
endinterface

// ===== rtl/core/owrm_result_if.sv =====
// owrm_result_if: output channel carrying one result word per tick
// depends on owrm_pkg for field widths
interface owrm_result_if;
    logic                             valid;
    logic                             ready;
    logic                             drive_low;
    logic                             busy_res;
    logic                             done_res;
    logic [owrm_pkg::STATUS_W-1:0]    status;
    logic [7:0]                       family_code;
    logic [owrm_pkg::SERIAL_W-1:0]    serial_number;
    logic [7:0]                       crc_byte;

    modport source (output valid, output drive_low, output busy_res, output done_res,
                    output status, output family_code, output serial_number,
                    output crc_byte, input ready);
    modport sink   (input valid, input drive_low, input busy_res, input done_res,
                    input status, input family_code, input serial_number,
                    input crc_byte, output ready);
endinterface

// ===== rtl/core/owrm_cfg_regs.sv =====
// owrm_cfg_regs: timing configuration registers with a plain write port
// depends on owrm_pkg
module owrm_cfg_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [owrm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [owrm_pkg::CFG_DATA_W-1:0] cfg_data,
    output owrm_pkg::cfg_t                 cfg
);
    import owrm_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                REG_RESET_LOW_TICKS:      cfg_next.reset_low_ticks      = cfg_data;
                REG_PRESENCE_SAMPLE_TICK: cfg_next.presence_sample_tick = cfg_data;
                REG_RESET_HIGH_TICKS:     cfg_next.reset_high_ticks     = cfg_data;
                REG_SLOT_TICKS:           cfg_next.slot_ticks           = cfg_data[SLOT_W-1:0];
                REG_WRITE_ZERO_LOW_TICKS: cfg_next.write_zero_low_ticks = cfg_data[SLOT_W-1:0];
                REG_WRITE_ONE_LOW_TICKS:  cfg_next.write_one_low_ticks  = cfg_data[SLOT_W-1:0];
                REG_READ_LOW_TICKS:       cfg_next.read_low_ticks       = cfg_data[SLOT_W-1:0];
                REG_READ_SAMPLE_TICK:     cfg_next.read_sample_tick     = cfg_data[SLOT_W-1:0];
                default:                  cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.reset_low_ticks      <= RST_RESET_LOW_TICKS;
            cfg_reg.presence_sample_tick <= RST_PRESENCE_SAMPLE_TICK;
            cfg_reg.reset_high_ticks     <= RST_RESET_HIGH_TICKS;
            cfg_reg.slot_ticks           <= RST_SLOT_TICKS;
            cfg_reg.write_zero_low_ticks <= RST_WRITE_ZERO_LOW_TICKS;
            cfg_reg.write_one_low_ticks  <= RST_WRITE_ONE_LOW_TICKS;
            cfg_reg.read_low_ticks       <= RST_READ_LOW_TICKS;
            cfg_reg.read_sample_tick     <= RST_READ_SAMPLE_TICK;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== rtl/core/owrm_seq.sv =====
// owrm_seq: bus sequencer state, one step per accepted tick word, plus crc and rom capture
// depends on owrm_pkg
module owrm_seq (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic              start_req,
    input  logic              line_level,
    input  owrm_pkg::cfg_t    cfg,
    output owrm_pkg::result_t res
);
    import owrm_pkg::*;

    phase_t            phase_reg, phase_next;
    logic [TICK_W-1:0] tick_reg, tick_next;
    logic [2:0]        bit_reg, bit_next;
    logic [2:0]        byte_reg, byte_next;
    logic [ROM_W-1:0]  rom_reg, rom_next;
    logic [7:0]        crc_reg, crc_next;
    logic [STATUS_W-1:0] status_reg, status_next;

    logic              done;
    logic              cmd_bit;
    logic [TICK_W-1:0] tick_inc;
    logic [TICK_W:0]   tick_p1;
    logic [SLOT_W-1:0] wr_low_len;
    logic [SLOT_W-1:0] wr_rel_len;
    logic [SLOT_W-1:0] rd_rel_len;
    logic [SLOT_W-1:0] rd_sample;
    logic [ROM_W-1:0]  rom_set;
    logic [7:0]        rd_byte;

    assign cmd_bit    = CMD_READ_ROM[bit_reg];
    assign tick_inc   = tick_reg + 1'b1;
    assign tick_p1    = {1'b0, tick_reg} + 1'b1;
    assign wr_low_len = cmd_bit ? cfg.write_one_low_ticks : cfg.write_zero_low_ticks;
    assign wr_rel_len = cmd_bit ? sub_sat(cfg.slot_ticks, cfg.write_one_low_ticks)
                                : RECOVERY_TICKS;
    assign rd_rel_len = sub_sat(cfg.slot_ticks, cfg.read_low_ticks);
    assign rd_sample  = sub_sat(cfg.read_sample_tick, cfg.read_low_ticks);

    always_comb
    begin
        rom_set = rom_reg;
        if ((tick_reg == TICK_W'(rd_sample)) && line_level)
        begin
            rom_set = rom_reg | (ROM_W'(1) << {byte_reg, bit_reg});
        end
    end

    assign rd_byte = rom_set[{byte_reg, 3'b000} +: 8];

    always_comb
    begin
        phase_next  = phase_reg;
        tick_next   = tick_reg;
        bit_next    = bit_reg;
        byte_next   = byte_reg;
        rom_next    = rom_reg;
        crc_next    = crc_reg;
        status_next = status_reg;
        done        = 1'b0;
        case (phase_reg)
            PH_IDLE:
            begin
                if (start_req)
                begin
                    rom_next    = '0;
                    crc_next    = '0;
                    status_next = STATUS_CRC_OK;
                    bit_next    = '0;
                    byte_next   = '0;
                    tick_next   = '0;
                    phase_next  = PH_RST_LOW;
                end
            end
            PH_RST_LOW:
            begin
                if (tick_p1 >= {1'b0, cfg.reset_low_ticks})
                begin
                    phase_next = PH_RST_HIGH;
                    tick_next  = '0;
                end
                else
                begin
                    tick_next = tick_inc;
                end
            end
            PH_RST_HIGH:
            begin
                if ((tick_reg == cfg.presence_sample_tick) && line_level)
                begin
                    status_next = STATUS_NO_PRESENCE;
                    done        = 1'b1;
                    phase_next  = PH_IDLE;
                    tick_next   = '0;
                end
                else if ((tick_reg >= cfg.presence_sample_tick) &&
                         (tick_p1 >= {1'b0, cfg.reset_high_ticks}))
                begin
                    phase_next = PH_WR_LOW;
                    tick_next  = '0;
                    bit_next   = '0;
                end
                else
                begin
                    tick_next = tick_inc;
                end
            end
            PH_WR_LOW:
            begin
                if (tick_p1 >= (TICK_W+1)'(wr_low_len))
                begin
                    phase_next = PH_WR_REL;
                    tick_next  = '0;
                end
                else
                begin
                    tick_next = tick_inc;
                end
            end
            PH_WR_REL:
            begin
                if (tick_p1 >= (TICK_W+1)'(wr_rel_len))
                begin
                    tick_next = '0;
                    if (bit_reg == 3'd7)
                    begin
                        bit_next   = '0;
                        byte_next  = '0;
                        phase_next = PH_RD_LOW;
                    end
                    else
                    begin
                        bit_next   = bit_reg + 1'b1;
                        phase_next = PH_WR_LOW;
                    end
                end
                else
                begin
                    tick_next = tick_inc;
                end
            end
            PH_RD_LOW:
            begin
                if (tick_p1 >= (TICK_W+1)'(cfg.read_low_ticks))
                begin
                    phase_next = PH_RD_REL;
                    tick_next  = '0;
                end
                else
                begin
                    tick_next = tick_inc;
                end
            end
            PH_RD_REL:
            begin
                rom_next = rom_set;
                if ((tick_reg >= TICK_W'(rd_sample)) &&
                    (tick_p1 >= (TICK_W+1)'(rd_rel_len)))
                begin
                    tick_next  = '0;
                    phase_next = PH_RD_LOW;
                    if (bit_reg == 3'd7)
                    begin
                        bit_next = '0;
                        if (byte_reg == 3'd7)
                        begin
                            status_next = (crc_reg == rd_byte) ? STATUS_CRC_OK
                                                               : STATUS_CRC_FAIL;
                            done        = 1'b1;
                            phase_next  = PH_IDLE;
                        end
                        else
                        begin
                            crc_next  = crc8_step(crc_reg, rd_byte);
                            byte_next = byte_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        bit_next = bit_reg + 1'b1;
                    end
                end
                else
                begin
                    tick_next = tick_inc;
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
                tick_next  = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            tick_reg   <= '0;
            bit_reg    <= '0;
            byte_reg   <= '0;
            rom_reg    <= '0;
            crc_reg    <= '0;
            status_reg <= STATUS_CRC_OK;
        end
        else if (accept)
        begin
            phase_reg  <= phase_next;
            tick_reg   <= tick_next;
            bit_reg    <= bit_next;
            byte_reg   <= byte_next;
            rom_reg    <= rom_next;
            crc_reg    <= crc_next;
            status_reg <= status_next;
        end
    end

    assign res.drive_low     = (phase_reg == PH_RST_LOW) || (phase_reg == PH_WR_LOW) ||
                               (phase_reg == PH_RD_LOW);
    assign res.busy_res      = (phase_next != PH_IDLE);
    assign res.done_res      = done;
    assign res.status        = status_next;
    assign res.family_code   = rom_next[7:0];
    assign res.serial_number = rom_next[55:8];
    assign res.crc_byte      = rom_next[63:56];

endmodule

// ===== rtl/core/owrm_out_reg.sv =====
// owrm_out_reg: result register between the sequencer and the result channel
// depends on owrm_pkg and owrm_result_if
module owrm_out_reg (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  load_valid,
    input  owrm_pkg::result_t     load_data,
    output logic                  load_ready,
    owrm_result_if.source         result
);
    import owrm_pkg::*;

    logic    valid_reg, valid_next;
    result_t data_reg;

    assign load_ready = !valid_reg || result.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load_ready)
        begin
            valid_next = load_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_ready && load_valid)
        begin
            data_reg <= load_data;
        end
    end

    assign result.valid         = valid_reg;
    assign result.drive_low     = data_reg.drive_low;
    assign result.busy_res      = data_reg.busy_res;
    assign result.done_res      = data_reg.done_res;
    assign result.status        = data_reg.status;
    assign result.family_code   = data_reg.family_code;
    assign result.serial_number = data_reg.serial_number;
    assign result.crc_byte      = data_reg.crc_byte;

endmodule

// ===== rtl/core/onewire_read_rom_master_core.sv =====
// onewire_read_rom_master_core: top level of the 1-wire read rom master
// depends on owrm_pkg, owrm_tick_if, owrm_result_if, owrm_cfg_regs, owrm_seq, owrm_out_reg
//
// Each tick word is one bus microsecond and yields exactly one result word, registered as
// it is taken. A tick word is taken every clock while the result register is empty or its
// word is taken in the same cycle, so the block sustains one word per clock; the figure is
// set by the single sequencer step (phase, tick counter, bit and byte index, crc byte) that
// runs between the state registers and the result register. A transaction lasts as many
// tick words as the configured bus timings add up to. The user must write timing registers
// through the plain write port while no transaction is running; not enforced by the block.
module onewire_read_rom_master_core (
    input  logic                           clk,
    input  logic                           rst_n,
    owrm_tick_if.sink                      tick,
    owrm_result_if.source                  result,
    input  logic                           cfg_we,
    input  logic [owrm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [owrm_pkg::CFG_DATA_W-1:0] cfg_data
);
    import owrm_pkg::*;

    cfg_t    cfg;
    result_t step_res;
    logic    load_ready;
    logic    accept;

    assign tick.ready = load_ready;
    assign accept     = tick.valid && load_ready;

    owrm_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    owrm_seq u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .start_req  (tick.start_req),
        .line_level (tick.line_level),
        .cfg        (cfg),
        .res        (step_res)
    );

    owrm_out_reg u_out_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .load_valid (tick.valid),
        .load_data  (step_res),
        .load_ready (load_ready),
        .result     (result)
    );

`ifndef SYNTHESIS
    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.done_res |-> !result.busy_res)
        else $error("done word still flagged busy");

    a_no_presence_rom_clear: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.done_res && (result.status == STATUS_NO_PRESENCE)
        |-> (result.family_code == 8'd0) && (result.crc_byte == 8'd0) &&
            (result.serial_number == '0))
        else $error("rom fields set after missing presence pulse");

    a_stall_blocks_tick: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && !result.ready |-> !tick.ready)
        else $error("tick taken while result word is stalled");

    a_drive_only_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept && step_res.drive_low |=> result.valid && result.drive_low &&
            $past(step_res.busy_res || step_res.done_res || step_res.drive_low))
        else $error("line driven outside a transaction");
`endif

endmodule

// ===== tb/tb_onewire_read_rom_master_core.sv =====
// tb_onewire_read_rom_master_core: self-checking bench for the 1-wire read rom master core,
// emulating a bus device on the tick stream and predicting every result word in lock-step
// depends on owrm_pkg, owrm_tick_if, owrm_result_if and onewire_read_rom_master_core
`timescale 1ns / 100ps

module tb_onewire_read_rom_master_core;

    import owrm_pkg::*;

    typedef struct packed {
        logic start;
        logic line;
    } tick_word_t;

    typedef struct packed {
        phase_t      ph;
        logic [9:0]  ticks;
        logic [2:0]  bit_i;
        logic [3:0]  byte_i;
        logic [63:0] rom;
        logic [7:0]  crc;
        logic [1:0]  stat;
    } bus_state_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    owrm_tick_if   tick_ch ();
    owrm_result_if result_ch ();

    onewire_read_rom_master_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .tick      (tick_ch),
        .result    (result_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    cfg_t        timing;
    bus_state_t  plan_state;
    bus_state_t  check_state;
    tick_word_t  tick_plan[$];
    result_t     predicted_bus_words[$];
    bit          tick_taken;
    bit          drain_hold;
    bit          gaps_on;
    int unsigned send_gap;
    int unsigned stall_left;
    int unsigned mismatches;
    int unsigned planned_ticks;
    int unsigned finished_transactions;

    always #6 clk = ~clk;

    function automatic int unsigned sat_diff(input int unsigned a, input int unsigned b);
        return (a > b) ? (a - b) : 0;
    endfunction

    function automatic bit span_over(input logic [9:0] cnt, input int unsigned len);
        return ({22'd0, cnt} + 32'd1) >= len;
    endfunction

    function automatic logic [7:0] fold_crc8(input logic [7:0] acc, input logic [7:0] data);
        logic [7:0] c;
        c = acc ^ data;
        for (int i = 0; i < 8; i++)
        begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    function automatic bus_state_t idle_state();
        bus_state_t st;
        st = '0;
        st.ph = PH_IDLE;
        return st;
    endfunction

    function automatic cfg_t default_timing();
        cfg_t c;
        c.reset_low_ticks      = RST_RESET_LOW_TICKS;
        c.presence_sample_tick = RST_PRESENCE_SAMPLE_TICK;
        c.reset_high_ticks     = RST_RESET_HIGH_TICKS;
        c.slot_ticks           = RST_SLOT_TICKS;
        c.write_zero_low_ticks = RST_WRITE_ZERO_LOW_TICKS;
        c.write_one_low_ticks  = RST_WRITE_ONE_LOW_TICKS;
        c.read_low_ticks       = RST_READ_LOW_TICKS;
        c.read_sample_tick     = RST_READ_SAMPLE_TICK;
        return c;
    endfunction

    // one bus microsecond of the sequencer, returns the word it shows
    function automatic result_t step_read_rom(inout bus_state_t st, input cfg_t c,
                                              input logic start, input logic line);
        result_t     r;
        phase_t      was;
        logic        cmd_bit;
        logic        done;
        logic [7:0]  rx_byte;
        int unsigned s;
        was     = st.ph;
        done    = 1'b0;
        cmd_bit = CMD_READ_ROM[st.bit_i];
        s       = sat_diff(c.read_sample_tick, c.read_low_ticks);
        case (st.ph)
            PH_IDLE:
            begin
                if (start)
                begin
                    st.rom    = '0;
                    st.crc    = '0;
                    st.stat   = STATUS_CRC_OK;
                    st.bit_i  = '0;
                    st.byte_i = '0;
                    st.ticks  = '0;
                    st.ph     = PH_RST_LOW;
                end
            end
            PH_RST_LOW:
            begin
                if (span_over(st.ticks, c.reset_low_ticks))
                begin
                    st.ph    = PH_RST_HIGH;
                    st.ticks = '0;
                end
                else
                    st.ticks++;
            end
            PH_RST_HIGH:
            begin
                if (st.ticks == c.presence_sample_tick && line)
                begin
                    st.stat  = STATUS_NO_PRESENCE;
                    done     = 1'b1;
                    st.ph    = PH_IDLE;
                    st.ticks = '0;
                end
                else if (st.ticks >= c.presence_sample_tick
                         && span_over(st.ticks, c.reset_high_ticks))
                begin
                    st.ph    = PH_WR_LOW;
                    st.ticks = '0;
                    st.bit_i = '0;
                end
                else
                    st.ticks++;
            end
            PH_WR_LOW:
            begin
                if (span_over(st.ticks, cmd_bit ? c.write_one_low_ticks
                                                : c.write_zero_low_ticks))
                begin
                    st.ph    = PH_WR_REL;
                    st.ticks = '0;
                end
                else
                    st.ticks++;
            end
            PH_WR_REL:
            begin
                if (span_over(st.ticks, cmd_bit ? sat_diff(c.slot_ticks, c.write_one_low_ticks)
                                                : RECOVERY_TICKS))
                begin
                    st.ticks = '0;
                    if (st.bit_i == 3'd7)
                    begin
                        st.bit_i  = '0;
                        st.byte_i = '0;
                        st.ph     = PH_RD_LOW;
                    end
                    else
                    begin
                        st.bit_i++;
                        st.ph = PH_WR_LOW;
                    end
                end
                else
                    st.ticks++;
            end
            PH_RD_LOW:
            begin
                if (span_over(st.ticks, c.read_low_ticks))
                begin
                    st.ph    = PH_RD_REL;
                    st.ticks = '0;
                end
                else
                    st.ticks++;
            end
            PH_RD_REL:
            begin
                if ({22'd0, st.ticks} == s && line)
                    st.rom[{st.byte_i[2:0], st.bit_i}] = 1'b1;
                if ({22'd0, st.ticks} >= s
                    && span_over(st.ticks, sat_diff(c.slot_ticks, c.read_low_ticks)))
                begin
                    st.ticks = '0;
                    st.ph    = PH_RD_LOW;
                    if (st.bit_i == 3'd7)
                    begin
                        rx_byte  = st.rom[{st.byte_i[2:0], 3'b000} +: 8];
                        st.bit_i = '0;
                        if (st.byte_i >= 4'd7)
                        begin
                            st.stat = (st.crc == rx_byte) ? STATUS_CRC_OK : STATUS_CRC_FAIL;
                            done    = 1'b1;
                            st.ph   = PH_IDLE;
                        end
                        else
                        begin
                            st.crc = fold_crc8(st.crc, rx_byte);
                            st.byte_i++;
                        end
                    end
                    else
                        st.bit_i++;
                end
                else
                    st.ticks++;
            end
            default:
            begin
                st.ph    = PH_IDLE;
                st.ticks = '0;
            end
        endcase
        r.drive_low     = (was == PH_RST_LOW) || (was == PH_WR_LOW) || (was == PH_RD_LOW);
        r.busy_res      = (st.ph != PH_IDLE);
        r.done_res      = done;
        r.status        = st.stat;
        r.family_code   = st.rom[7:0];
        r.serial_number = st.rom[55:8];
        r.crc_byte      = st.rom[63:56];
        return r;
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(6, 20);
    endfunction

    function automatic logic [63:0] seal_rom(input logic [55:0] body, input bit good);
        logic [7:0] sum;
        sum = '0;
        for (int i = 0; i < 7; i++)
        begin
            sum = fold_crc8(sum, body[i*8 +: 8]);
        end
        if (!good)
            sum = sum ^ 8'($urandom_range(1, 255));
        return {sum, body};
    endfunction

    function automatic logic [9:0] small_val(input int unsigned hi);
        if ($urandom_range(0, 99) < 15)
            return '0;
        return 10'($urandom_range(0, hi));
    endfunction

    function automatic cfg_t rand_timing();
        cfg_t c;
        c.reset_low_ticks      = small_val(8);
        c.presence_sample_tick = small_val(6);
        c.reset_high_ticks     = small_val(10);
        c.slot_ticks           = 8'(small_val(4));
        c.write_zero_low_ticks = 8'(small_val(6));
        c.write_one_low_ticks  = 8'(small_val(6));
        c.read_low_ticks       = 8'(small_val(2));
        c.read_sample_tick     = 8'(small_val(4));
        return c;
    endfunction

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got)
        begin
            $error("%s expected %0h got %0h", name, want, got);
            mismatches++;
        end
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [9:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        case (idx)
            REG_RESET_LOW_TICKS:      timing.reset_low_ticks      = data;
            REG_PRESENCE_SAMPLE_TICK: timing.presence_sample_tick = data;
            REG_RESET_HIGH_TICKS:     timing.reset_high_ticks     = data;
            REG_SLOT_TICKS:           timing.slot_ticks           = data[7:0];
            REG_WRITE_ZERO_LOW_TICKS: timing.write_zero_low_ticks = data[7:0];
            REG_WRITE_ONE_LOW_TICKS:  timing.write_one_low_ticks  = data[7:0];
            REG_READ_LOW_TICKS:       timing.read_low_ticks       = data[7:0];
            REG_READ_SAMPLE_TICK:     timing.read_sample_tick     = data[7:0];
            default:                  ;
        endcase
    endtask

    // upper data bits of the 8-bit registers carry junk
    task automatic apply_timing(input cfg_t c);
        write_reg(REG_RESET_LOW_TICKS, c.reset_low_ticks);
        write_reg(REG_PRESENCE_SAMPLE_TICK, c.presence_sample_tick);
        write_reg(REG_RESET_HIGH_TICKS, c.reset_high_ticks);
        write_reg(REG_SLOT_TICKS, {2'($urandom_range(0, 3)), c.slot_ticks});
        write_reg(REG_WRITE_ZERO_LOW_TICKS, {2'($urandom_range(0, 3)), c.write_zero_low_ticks});
        write_reg(REG_WRITE_ONE_LOW_TICKS, {2'($urandom_range(0, 3)), c.write_one_low_ticks});
        write_reg(REG_READ_LOW_TICKS, {2'($urandom_range(0, 3)), c.read_low_ticks});
        write_reg(REG_READ_SAMPLE_TICK, {2'($urandom_range(0, 3)), c.read_sample_tick});
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic push_tick(input logic start, input logic line);
        tick_word_t w;
        w.start = start;
        w.line  = line;
        tick_plan.push_back(w);
        void'(step_read_rom(plan_state, timing, start, line));
        planned_ticks++;
    endtask

    // device side of one read rom; flip_odds nonzero corrupts some read bits
    task automatic queue_transaction(input bit absent, input logic [63:0] rom_image,
                                     input int unsigned flip_odds);
        int unsigned idle_n;
        logic        ln;
        idle_n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
        for (int k = 0; k < idle_n; k++)
        begin
            push_tick(1'b0, 1'($urandom_range(0, 1)));
        end
        push_tick(1'b1, 1'($urandom_range(0, 1)));
        while (plan_state.ph != PH_IDLE)
        begin
            ln = 1'($urandom_range(0, 1));
            if (plan_state.ph == PH_RST_HIGH
                && plan_state.ticks == timing.presence_sample_tick)
                ln = absent;
            else if (plan_state.ph == PH_RD_REL && {22'd0, plan_state.ticks}
                     == sat_diff(timing.read_sample_tick, timing.read_low_ticks))
            begin
                ln = rom_image[{plan_state.byte_i[2:0], plan_state.bit_i}];
                if (flip_odds != 0 && $urandom_range(1, flip_odds) == 1)
                    ln = ~ln;
            end
            push_tick($urandom_range(0, 19) == 0, ln);
        end
        finished_transactions++;
    endtask

    task automatic settle();
        while (tick_plan.size() != 0 || tick_ch.valid || predicted_bus_words.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // sender
    always @(negedge clk)
    begin
        tick_word_t w;
        if (rst_n && (!tick_ch.valid || tick_taken))
        begin
            if (send_gap > 0)
            begin
                send_gap--;
                tick_ch.valid <= 1'b0;
            end
            else if (drain_hold)
            begin
                if (predicted_bus_words.size() == 0)
                    drain_hold = 1'b0;
                tick_ch.valid <= 1'b0;
            end
            else if (tick_plan.size() != 0)
            begin
                w = tick_plan.pop_front();
                tick_ch.start_req  <= w.start;
                tick_ch.line_level <= w.line;
                tick_ch.valid      <= 1'b1;
                send_gap = gaps_on ? pick_gap() : 0;
                if ($urandom_range(0, 63) == 0)
                    drain_hold = 1'b1;
            end
            else
                tick_ch.valid <= 1'b0;
        end
    end

    // receiver
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (stall_left > 0)
            begin
                stall_left--;
                result_ch.ready <= 1'b0;
            end
            else
            begin
                result_ch.ready <= 1'b1;
                if (gaps_on && $urandom_range(0, 3) == 0)
                    stall_left = pick_gap();
            end
        end
    end

    // checker
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n)
        begin
            if (result_ch.valid && result_ch.ready)
            begin
                if (predicted_bus_words.size() == 0)
                begin
                    $error("result word with nothing expected");
                    mismatches++;
                end
                else
                begin
                    want = predicted_bus_words.pop_front();
                    check_field("drive_low", want.drive_low, result_ch.drive_low);
                    check_field("busy_res", want.busy_res, result_ch.busy_res);
                    check_field("done_res", want.done_res, result_ch.done_res);
                    check_field("status", want.status, result_ch.status);
                    check_field("family_code", want.family_code, result_ch.family_code);
                    check_field("serial_number", want.serial_number,
                                result_ch.serial_number);
                    check_field("crc_byte", want.crc_byte, result_ch.crc_byte);
                end
            end
            tick_taken = tick_ch.valid && tick_ch.ready;
            if (tick_taken)
                predicted_bus_words.push_back(step_read_rom(check_state, timing,
                                                            tick_ch.start_req,
                                                            tick_ch.line_level));
        end
    end

    initial
    begin
        int unsigned first_tick;
        int unsigned first_done;
        int unsigned n;
        int unsigned r;
        clk                  = 1'b0;
        rst_n                = 1'b0;
        cfg_we               = 1'b0;
        cfg_index            = REG_RESET_LOW_TICKS;
        cfg_data             = '0;
        tick_ch.valid        = 1'b0;
        tick_ch.start_req    = 1'b0;
        tick_ch.line_level   = 1'b1;
        result_ch.ready      = 1'b0;
        tick_taken           = 1'b0;
        drain_hold           = 1'b0;
        gaps_on              = 1'b1;
        send_gap             = 0;
        stall_left           = 0;
        mismatches           = 0;
        planned_ticks        = 0;
        finished_transactions = 0;
        timing               = default_timing();
        plan_state           = idle_state();
        check_state          = idle_state();
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // idle words as they come out of reset
        for (int k = 0; k < 4; k++)
        begin
            push_tick(1'b0, 1'($urandom_range(0, 1)));
        end
        settle();

        // shortest intervals
        apply_timing('0);
        queue_transaction(1'b1, '0, 0);
        queue_transaction(1'b0, seal_rom({56{1'b1}}, 1'b1), 0);
        queue_transaction(1'b0, seal_rom(56'({$urandom, $urandom}), 1'b0), 0);
        settle();

        first_tick = planned_ticks;
        first_done = finished_transactions;
        while (finished_transactions - first_done < 3 || planned_ticks - first_tick < 350)
        begin
            gaps_on = ($urandom_range(0, 3) != 0);
            apply_timing(rand_timing());
            n = $urandom_range(1, 2);
            for (int k = 0; k < n; k++)
            begin
                r = $urandom_range(0, 99);
                if (r < 25)
                    queue_transaction(1'b1, '0, 0);
                else if (r < 40)
                    queue_transaction(1'b0, seal_rom(56'({$urandom, $urandom}), 1'b1), 64);
                else
                    queue_transaction(1'b0, seal_rom(56'({$urandom, $urandom}),
                                                     $urandom_range(0, 3) != 0), 0);
            end
            settle();
        end

        repeat (10) @(posedge clk);
        if (mismatches == 0 && predicted_bus_words.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/owrm_pkg.sv
rtl/core/owrm_tick_if.sv
rtl/core/owrm_result_if.sv
rtl/core/owrm_cfg_regs.sv
rtl/core/owrm_seq.sv
rtl/core/owrm_out_reg.sv
rtl/core/onewire_read_rom_master_core.sv
tb/tb_onewire_read_rom_master_core.sv
